// File: hw/rtl/ped_pkg.sv
// Shared types and constants for the pit edge detector.
package ped_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int DIM_W      = 11;
  localparam int COORD_W    = 10;
  localparam int THR_W      = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_ROWS       = 3'd0,
    CFG_MAP_COLS       = 3'd1,
    CFG_BOX_ROW_MIN    = 3'd2,
    CFG_BOX_ROW_MAX    = 3'd3,
    CFG_BOX_COL_MIN    = 3'd4,
    CFG_BOX_COL_MAX    = 3'd5,
    CFG_EDGE_THRESHOLD = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_FLUSH  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [COORD_W-1:0] cell_row;
    logic [COORD_W-1:0] cell_col;
    logic               is_edge;
    logic               last_cell;
  } res_t;

endpackage

// File: hw/rtl/ped_line_mem.sv
// Line buffer RAM: one write port, one read port with registered read data.
module ped_line_mem #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read returns the old contents on a same-address write; caller forwards
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/ped_skid.sv
// Two-entry result buffer: output register plus skid register.
module ped_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ped_pkg::res_t     push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ped_pkg::res_t     out_data_o
);
  import ped_pkg::*;

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic pop;

  assign pop = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = push_i;
        skid_d       = push_data_i;
      end else begin
        out_valid_d = push_i;
        out_d       = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hw/rtl/pit_edge_detector.sv
// Top level: streaming four-neighbor pit edge detector over a raster elevation map.
//
//   port group   dir   handshake              payload
//   in           in    in_valid_i/in_stall_o  command_i, elevation_i
//   out          out   out_valid_o/out_stall_i cell_row_o, cell_col_o, is_edge_o, last_cell_o
//   cfg          in    cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// One beat per cycle while in_stall_o is low; results are registered in ped_skid.
// Each non-ignored beat does one read and one write of the line RAM, whose read is issued
// two columns ahead so neighbor data is ready when the next beat lands.
// Reset or any cfg write restarts the frame at row 0, column 0; RAM contents
// are not cleared (row 0 is never judged). in_stall_o rises only once both
// result registers are full.
module pit_edge_detector #(
  parameter int MAX_ROWS  = 1024,
  parameter int MAX_COLS  = 1024,
  parameter int ELEV_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              command_i,
  input  logic signed [ELEV_BITS-1:0]       elevation_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ped_pkg::COORD_W-1:0]       cell_row_o,
  output logic [ped_pkg::COORD_W-1:0]       cell_col_o,
  output logic                              is_edge_o,
  output logic                              last_cell_o,
  input  logic                              cfg_we_i,
  input  logic [ped_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ped_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import ped_pkg::*;

  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int CA = $clog2(MAX_COLS);
  localparam int EW = 2 * ELEV_BITS;
  localparam int DW = (ELEV_BITS + 1 > 16) ? ELEV_BITS + 1 : 16;

  // config registers
  logic [DIM_W-1:0]   map_rows_q, map_cols_q;
  logic [COORD_W-1:0] box_row_min_q, box_row_max_q, box_col_min_q, box_col_max_q;
  logic [THR_W-1:0]   edge_threshold_q;

  // frame position
  logic [RW-1:0] row_q, row_d;
  logic [CA-1:0] col_q, col_d;

  // entry = {upper, middle}
  logic [EW-1:0] cur_q, cur_d;
  logic [EW-1:0] fwd_data_q;
  logic          fwd_q;
  logic [EW-1:0] rd_data, nxt_entry, wr_entry;
  logic signed [ELEV_BITS-1:0] prev_ctr_q;

  logic [RW-1:0] rows, r_eff, jr, r_nx;
  logic [CW-1:0] cols, c1, c2;
  logic [CA-1:0] c_eff, next_c, rd_addr;
  logic          bad_pos, flush, ignore, accept, act, judge, in_box, wrap;

  logic signed [ELEV_BITS-1:0] ctr;
  logic signed [ELEV_BITS-1:0] nb [4];
  logic        [3:0]           nb_ok;
  logic signed [DW-1:0]        diff [4];
  logic        [3:0]           hit;
  logic signed [DW-1:0]        thr;

  logic skid_full;
  logic push;
  res_t res, out_res;

  // clamp dimensions to 1..MAX
  always_comb begin
    if (map_rows_q == '0) begin
      rows = RW'(1);
    end else if (32'(map_rows_q) > 32'(MAX_ROWS)) begin
      rows = RW'(MAX_ROWS);
    end else begin
      rows = RW'(map_rows_q);
    end
    if (map_cols_q == '0) begin
      cols = CW'(1);
    end else if (32'(map_cols_q) > 32'(MAX_COLS)) begin
      cols = CW'(MAX_COLS);
    end else begin
      cols = CW'(map_cols_q);
    end
  end

  assign bad_pos = (row_q > rows) || (CW'(col_q) >= cols);
  assign r_eff   = bad_pos ? '0 : row_q;
  assign c_eff   = bad_pos ? '0 : col_q;
  assign flush   = (r_eff == rows);
  assign ignore  = !flush && (cmd_e'(command_i) == CMD_FLUSH);
  assign in_stall_o = skid_full;
  assign accept  = in_valid_i && !in_stall_o;
  assign act     = accept && !ignore;
  assign judge   = (r_eff != '0);
  assign jr      = r_eff - RW'(1);

  // column stepping and read-ahead address (two columns on, modulo width)
  assign c1      = CW'(c_eff) + CW'(1);
  assign wrap    = (c1 >= cols);
  assign next_c  = wrap ? '0 : CA'(c1);
  assign c2      = CW'(next_c) + CW'(1);
  assign rd_addr = (c2 >= cols) ? '0 : CA'(c2);
  assign r_nx    = (r_eff == rows) ? '0 : r_eff + RW'(1);

  assign nxt_entry = fwd_q ? fwd_data_q : rd_data;
  assign ctr       = cur_q[ELEV_BITS-1:0];
  assign wr_entry  = {cur_q[ELEV_BITS-1:0], flush ? cur_q[ELEV_BITS-1:0] : elevation_i};
  // single-column map: next entry is the one being written now
  assign cur_d     = (next_c == c_eff) ? wr_entry : nxt_entry;

  // neighbors: up, down, left, right
  always_comb begin
    nb[0]    = cur_q[EW-1:ELEV_BITS];
    nb[1]    = elevation_i;
    nb[2]    = prev_ctr_q;
    nb[3]    = nxt_entry[ELEV_BITS-1:0];
    nb_ok[0] = (r_eff >= RW'(2));
    nb_ok[1] = !flush;
    nb_ok[2] = (c_eff != '0);
    nb_ok[3] = !wrap;
  end

  assign thr = $signed(DW'(edge_threshold_q));

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      diff[d] = DW'(ctr) - DW'(nb[d]);
      hit[d]  = nb_ok[d] && (diff[d] > thr);
    end
  end

  assign in_box = (32'(jr) >= 32'(box_row_min_q)) && (32'(jr) <= 32'(box_row_max_q)) &&
                  (32'(c_eff) >= 32'(box_col_min_q)) && (32'(c_eff) <= 32'(box_col_max_q));

  // inside the box, last row is box max or map bottom, whichever comes first
  always_comb begin
    res.cell_row  = COORD_W'(jr);
    res.cell_col  = COORD_W'(c_eff);
    res.is_edge   = |hit;
    res.last_cell = ((32'(jr) == 32'(box_row_max_q)) || (jr == rows - RW'(1))) &&
                    ((32'(c_eff) == 32'(box_col_max_q)) || (CW'(c_eff) == cols - CW'(1)));
  end

  assign push = act && judge && in_box;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cfg_we_i) begin
      row_d = '0;
      col_d = '0;
    end else if (accept) begin
      if (ignore) begin
        row_d = r_eff;
        col_d = c_eff;
      end else begin
        col_d = next_c;
        row_d = wrap ? r_nx : r_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_rows_q       <= DIM_W'(1024);
      map_cols_q       <= DIM_W'(1024);
      box_row_min_q    <= '0;
      box_row_max_q    <= COORD_W'(1023);
      box_col_min_q    <= '0;
      box_col_max_q    <= COORD_W'(1023);
      edge_threshold_q <= THR_W'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MAP_ROWS:       map_rows_q       <= cfg_wdata_i[DIM_W-1:0];
        CFG_MAP_COLS:       map_cols_q       <= cfg_wdata_i[DIM_W-1:0];
        CFG_BOX_ROW_MIN:    box_row_min_q    <= cfg_wdata_i[COORD_W-1:0];
        CFG_BOX_ROW_MAX:    box_row_max_q    <= cfg_wdata_i[COORD_W-1:0];
        CFG_BOX_COL_MIN:    box_col_min_q    <= cfg_wdata_i[COORD_W-1:0];
        CFG_BOX_COL_MAX:    box_col_max_q    <= cfg_wdata_i[COORD_W-1:0];
        CFG_EDGE_THRESHOLD: edge_threshold_q <= cfg_wdata_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      fwd_q <= 1'b0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      if (act) begin
        fwd_q <= (rd_addr == c_eff);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (act) begin
      cur_q      <= cur_d;
      fwd_data_q <= wr_entry;
      prev_ctr_q <= ctr;
    end
  end

  ped_line_mem #(
    .DEPTH  (MAX_COLS),
    .DATA_W (EW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (act),
    .waddr_i (c_eff),
    .wdata_i (wr_entry),
    .re_i    (act),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  ped_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign cell_row_o  = out_res.cell_row;
  assign cell_col_o  = out_res.cell_col;
  assign is_edge_o   = out_res.is_edge;
  assign last_cell_o = out_res.last_cell;

endmodule
